### rtl/core/lsb_stego_message_extractor_core_macros.svh
// Assertion macros for the LSB extractor core.
`ifndef LSB_STEGO_MESSAGE_EXTRACTOR_CORE_MACROS_SVH
`define LSB_STEGO_MESSAGE_EXTRACTOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LSME_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsme assertion failed");

// Next-cycle implication, disabled in reset.
`define LSME_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsme assertion failed");

`endif

### rtl/core/lsme_pkg.sv
`timescale 1ns / 1ps

package lsme_pkg;

  localparam int MARKER_BYTES = 4;
  localparam int LENGTH_BYTES = 4;
  localparam int HEADER_BYTES = MARKER_BYTES + LENGTH_BYTES;
  localparam int HPOS_W       = 4;
  localparam int LEN_W        = 32;
  localparam int CFG_W        = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = 2;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_FOUND     = 2'd1,
    KIND_NO_MARKER = 2'd2,
    KIND_TOO_LONG  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_MESSAGE = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef enum logic {
    CFG_MARKER   = 1'b0,
    CFG_CAPACITY = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [23:0] pixel_rgb;
    logic        frame_start;
  } pixel_in_t;

  typedef struct packed {
    kind_t             result_kind;
    logic [7:0]        data_byte;
    logic [LEN_W-1:0]  message_length;
    logic              last;
  } result_t;

  // one assembled byte; first marks the first byte after a frame start
  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } byte_beat_t;

  // expected marker byte at header position pos; zero beyond the register
  function automatic logic [7:0] marker_byte(input logic [CFG_W-1:0] mv,
                                             input logic [HPOS_W-1:0] pos);
    int          idx;
    logic [63:0] ext;
    logic [63:0] sh;
    idx = MARKER_BYTES - 1 - int'(pos);
    ext = {{(64 - CFG_W){1'b0}}, mv};
    sh  = ext >> (8 * idx);
    return sh[7:0];
  endfunction

endpackage

### rtl/core/lsme_front.sv
`timescale 1ns / 1ps

module lsme_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_accept,
  input  lsme_pkg::pixel_in_t  in_data,
  output logic                 push,
  output lsme_pkg::byte_beat_t push_beat
);

  logic       active_r, active_nxt;
  logic [7:0] buf_r, buf_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       first_r, first_nxt;

  always_comb begin
    logic [7:0] bb;
    logic [2:0] c;
    logic       act;
    logic       fst;
    logic       emit;
    logic [7:0] ebyte;
    logic [2:0] bits;
    bb    = buf_r;
    c     = cnt_r;
    act   = active_r;
    fst   = first_r;
    emit  = 1'b0;
    ebyte = 8'd0;
    bits  = {in_data.pixel_rgb[16], in_data.pixel_rgb[8], in_data.pixel_rgb[0]};
    if (in_data.frame_start) begin
      act = 1'b1;
      bb  = 8'd0;
      c   = 3'd0;
      fst = 1'b1;
    end
    // red, green, blue low bits, MSB first
    for (int i = 0; i < 3; i++) begin
      bb = {bb[6:0], bits[2-i]};
      if (c == 3'd7) begin
        emit  = 1'b1;
        ebyte = bb;
        bb    = 8'd0;
        c     = 3'd0;
      end else begin
        c = c + 3'd1;
      end
    end
    push            = in_accept && act && emit;
    push_beat.data  = ebyte;
    push_beat.first = fst;
    if (in_accept) begin
      active_nxt = act;
      buf_nxt    = bb;
      cnt_nxt    = c;
      first_nxt  = push ? 1'b0 : fst;
    end else begin
      active_nxt = active_r;
      buf_nxt    = buf_r;
      cnt_nxt    = cnt_r;
      first_nxt  = first_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      buf_r    <= 8'd0;
      cnt_r    <= 3'd0;
      first_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      buf_r    <= buf_nxt;
      cnt_r    <= cnt_nxt;
      first_r  <= first_nxt;
    end
  end

endmodule

### rtl/core/lsme_queue.sv
`timescale 1ns / 1ps

module lsme_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lsme_pkg::byte_beat_t push_beat,
  input  logic                 pop,
  output lsme_pkg::byte_beat_t head,
  output logic                 full,
  output logic                 empty
);

  lsme_pkg::byte_beat_t mem [lsme_pkg::QUEUE_DEPTH];

  logic [lsme_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lsme_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lsme_pkg::QPTR_W:0]   count_r, count_nxt;

  assign full  = (count_r == (lsme_pkg::QPTR_W + 1)'(lsme_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (lsme_pkg::QPTR_W + 1)'(push) - (lsme_pkg::QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### rtl/core/lsme_back.sv
`timescale 1ns / 1ps

module lsme_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [lsme_pkg::CFG_W-1:0]   marker_value,
  input  logic [lsme_pkg::CFG_W-1:0]   message_capacity,
  input  lsme_pkg::byte_beat_t         head,
  input  logic                         q_empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output lsme_pkg::result_t            out_data
);

  localparam logic [lsme_pkg::HPOS_W-1:0] MARKER_END =
    lsme_pkg::HPOS_W'(lsme_pkg::MARKER_BYTES);
  localparam logic [lsme_pkg::HPOS_W-1:0] HEADER_END =
    lsme_pkg::HPOS_W'(lsme_pkg::HEADER_BYTES);

  lsme_pkg::phase_t                 phase_r, phase_nxt;
  logic [lsme_pkg::HPOS_W-1:0]      pos_r, pos_nxt;
  logic                             match_r, match_nxt;
  logic [lsme_pkg::LEN_W-1:0]       acc_r, acc_nxt;
  logic [lsme_pkg::LEN_W-1:0]       rem_r, rem_nxt;
  logic                             out_valid_r, out_valid_nxt;
  lsme_pkg::result_t                out_r, out_nxt;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    lsme_pkg::phase_t            ph;
    logic [lsme_pkg::HPOS_W-1:0] pos;
    logic                        mt;
    logic [lsme_pkg::LEN_W-1:0]  acc;
    logic [lsme_pkg::LEN_W-1:0]  rem;
    logic                        res_ok;
    lsme_pkg::result_t           res;
    ph     = phase_r;
    pos    = pos_r;
    mt     = match_r;
    acc    = acc_r;
    rem    = rem_r;
    res_ok = 1'b0;
    res    = '0;
    pop    = !q_empty && (!out_valid_r || !out_stall);
    if (pop) begin
      if (head.first) begin
        ph  = lsme_pkg::PH_HEADER;
        pos = '0;
        mt  = 1'b1;
        acc = '0;
        rem = '0;
      end
      unique case (ph)
        lsme_pkg::PH_HEADER: begin
          if (pos < MARKER_END) begin
            if (lsme_pkg::marker_byte(marker_value, pos) != head.data) begin
              mt = 1'b0;
            end
          end else begin
            acc = {acc[lsme_pkg::LEN_W-9:0], head.data};
          end
          pos = pos + 1'b1;
          if (pos == HEADER_END) begin
            res_ok = 1'b1;
            res.last = 1'b1;
            if (!mt) begin
              ph = lsme_pkg::PH_DONE;
              res.result_kind = lsme_pkg::KIND_NO_MARKER;
            end else if (acc > message_capacity) begin
              ph = lsme_pkg::PH_DONE;
              res.result_kind    = lsme_pkg::KIND_TOO_LONG;
              res.message_length = acc;
            end else begin
              rem = acc;
              ph  = (acc == '0) ? lsme_pkg::PH_DONE : lsme_pkg::PH_MESSAGE;
              res.result_kind    = lsme_pkg::KIND_FOUND;
              res.message_length = acc;
              res.last           = (acc == '0);
            end
          end
        end
        lsme_pkg::PH_MESSAGE: begin
          rem = rem - 1'b1;
          if (rem == '0) begin
            ph = lsme_pkg::PH_DONE;
          end
          res_ok          = 1'b1;
          res.result_kind = lsme_pkg::KIND_BYTE;
          res.data_byte   = head.data;
          res.last        = (rem == '0);
        end
        lsme_pkg::PH_IDLE, lsme_pkg::PH_DONE: begin
        end
      endcase
    end
    phase_nxt = ph;
    pos_nxt   = pos;
    match_nxt = mt;
    acc_nxt   = acc;
    rem_nxt   = rem;
    // output register: drains on take, reloads on a new result
    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    if (res_ok) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= lsme_pkg::PH_IDLE;
      pos_r       <= '0;
      match_r     <= 1'b1;
      acc_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      match_r     <= match_nxt;
      acc_r       <= acc_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

### rtl/core/lsb_stego_message_extractor_core.sv
`timescale 1ns / 1ps

// LSB steganography extractor. Takes one pixel per clock while in_stall is
// low; the low bits of red, green and blue are packed MSB first into bytes.
// A front stage builds bytes into a 4-entry byte queue; a back stage checks
// the marker and length header and fills a one-deep output register, so a
// result is held first in the queue, then in the output register. in_stall
// rises only when the byte queue is full, which happens only while out_stall
// holds the output register; with out_stall low the block sustains one
// pixel per cycle indefinitely. Configure marker and capacity while idle.
module lsb_stego_message_extractor_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lsme_pkg::pixel_in_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lsme_pkg::result_t           out_data,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [lsme_pkg::CFG_W-1:0]  cfg_wdata
);

  logic [lsme_pkg::CFG_W-1:0] marker_r, marker_nxt;
  logic [lsme_pkg::CFG_W-1:0] capacity_r, capacity_nxt;

  logic                 in_accept;
  logic                 push;
  lsme_pkg::byte_beat_t push_beat;
  logic                 pop;
  lsme_pkg::byte_beat_t head;
  logic                 q_full;
  logic                 q_empty;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    marker_nxt   = marker_r;
    capacity_nxt = capacity_r;
    if (cfg_we) begin
      unique case (lsme_pkg::cfg_index_t'(cfg_index))
        lsme_pkg::CFG_MARKER:   marker_nxt   = cfg_wdata;
        lsme_pkg::CFG_CAPACITY: capacity_nxt = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r   <= '0;
      capacity_r <= '0;
    end else begin
      marker_r   <= marker_nxt;
      capacity_r <= capacity_nxt;
    end
  end

  lsme_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_data   (in_data),
    .push      (push),
    .push_beat (push_beat)
  );

  lsme_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_beat (push_beat),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  lsme_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .marker_value     (marker_r),
    .message_capacity (capacity_r),
    .head             (head),
    .q_empty          (q_empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule

### rtl/core/lsme_checker.sv
`timescale 1ns / 1ps

`include "lsb_stego_message_extractor_core_macros.svh"

module lsme_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input lsme_pkg::pixel_in_t         in_data,
  input logic                        out_valid,
  input logic                        out_stall,
  input lsme_pkg::result_t           out_data
);

  `LSME_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && in_stall,
                   in_valid && $stable(in_data))

  `LSME_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
                   out_valid && $stable(out_data))

  `LSME_ASSERT_IMP(a_no_marker_final, clk, rst_n,
                   out_valid && out_data.result_kind == lsme_pkg::KIND_NO_MARKER,
                   out_data.last && out_data.message_length == '0 && out_data.data_byte == '0)

  `LSME_ASSERT_IMP(a_too_long_final, clk, rst_n,
                   out_valid && out_data.result_kind == lsme_pkg::KIND_TOO_LONG,
                   out_data.last && out_data.message_length != '0)

  `LSME_ASSERT_IMP(a_found_last_zero, clk, rst_n,
                   out_valid && out_data.result_kind == lsme_pkg::KIND_FOUND,
                   out_data.last == (out_data.message_length == '0))

endmodule

bind lsb_stego_message_extractor_core lsme_checker u_lsme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
